FILE: hw/rtl/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

	// Coordinate and derived arithmetic widths
	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;   // difference of two coordinates
	localparam int PROD_W  = 2 * DIFF_W;    // product of two differences
	localparam int CROSS_W = PROD_W + 1;    // difference of two products
	localparam int MAG_W   = DIFF_W;        // magnitude of a difference

	// One request: two directed segments
	typedef struct packed {
		logic signed [COORD_W-1:0] seg_a_start_x;
		logic signed [COORD_W-1:0] seg_a_start_y;
		logic signed [COORD_W-1:0] seg_a_end_x;
		logic signed [COORD_W-1:0] seg_a_end_y;
		logic signed [COORD_W-1:0] seg_b_start_x;
		logic signed [COORD_W-1:0] seg_b_start_y;
		logic signed [COORD_W-1:0] seg_b_end_x;
		logic signed [COORD_W-1:0] seg_b_end_y;
	} scp_seg_t;

	// One result
	typedef struct packed {
		logic                      hit;
		logic signed [COORD_W-1:0] cross_x;
		logic signed [COORD_W-1:0] cross_y;
	} scp_res_t;

	// Side information that rides along the divider
	typedef struct packed {
		logic                      hit;
		logic                      neg_x;
		logic                      neg_y;
		logic signed [COORD_W-1:0] base_x;
		logic signed [COORD_W-1:0] base_y;
	} scp_tag_t;

endpackage

FILE: hw/rtl/scp_round_div.sv
`timescale 1ns / 1ps

// Pipelined rounded scaling: q = round(mag * num / den), one multiplier bit per stage.
// Requires num < den; each step keeps rem < den with a quotient digit of 0, 1 or 2.
module scp_round_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_vld,
	input  scp_pkg::scp_tag_t               in_tag,
	input  logic [scp_pkg::CROSS_W-1:0]     num,
	input  logic [scp_pkg::CROSS_W-1:0]     den,
	input  logic [scp_pkg::MAG_W-1:0]       mag_x,
	input  logic [scp_pkg::MAG_W-1:0]       mag_y,
	output logic                            out_vld,
	output scp_pkg::scp_tag_t               out_tag,
	output logic [scp_pkg::MAG_W-1:0]       q_x,
	output logic [scp_pkg::MAG_W-1:0]       q_y
);

	localparam int CW    = scp_pkg::CROSS_W;
	localparam int MW    = scp_pkg::MAG_W;
	localparam int RW    = CW + 1;
	localparam int NSTEP = MW;

	typedef struct packed {
		logic [RW-1:0] r;
		logic [MW-1:0] q;
	} lane_t;

	// One long-division step with a partial product folded in
	function automatic lane_t div_step(input logic [RW-1:0] r, input logic b,
			input logic [CW-1:0] n, input logic [CW-1:0] d, input logic [MW-1:0] q);
		logic [RW-1:0] s;
		logic [RW-1:0] d1;
		logic [RW-1:0] d2;
		lane_t         o;
		s  = (r << 1) + (b ? RW'(n) : '0);
		d1 = RW'(d);
		d2 = d1 << 1;
		if (s >= d2) begin
			o.r = s - d2;
			o.q = {q[MW-2:0], 1'b0} + MW'(2);
		end else if (s >= d1) begin
			o.r = s - d1;
			o.q = {q[MW-2:0], 1'b0} + MW'(1);
		end else begin
			o.r = s;
			o.q = {q[MW-2:0], 1'b0};
		end
		return o;
	endfunction

	logic                 vld_s [0:NSTEP];
	scp_pkg::scp_tag_t    tag_s [0:NSTEP];
	logic [CW-1:0]        num_s [0:NSTEP];
	logic [CW-1:0]        den_s [0:NSTEP];
	logic [MW-1:0]        mx_s  [0:NSTEP];
	logic [MW-1:0]        my_s  [0:NSTEP];
	lane_t                lx_s  [0:NSTEP];
	lane_t                ly_s  [0:NSTEP];

	// Stage zero is the request itself
	assign vld_s[0] = in_vld;
	assign tag_s[0] = in_tag;
	assign num_s[0] = num;
	assign den_s[0] = den;
	assign mx_s[0]  = mag_x;
	assign my_s[0]  = mag_y;
	assign lx_s[0]  = '0;
	assign ly_s[0]  = '0;

	// Division steps, multiplier bits taken MSB first
	for (genvar k = 1; k <= NSTEP; k++) begin : g_step
		lane_t nx;
		lane_t ny;

		assign nx = div_step(lx_s[k-1].r, mx_s[k-1][MW-1], num_s[k-1], den_s[k-1],
			lx_s[k-1].q);
		assign ny = div_step(ly_s[k-1].r, my_s[k-1][MW-1], num_s[k-1], den_s[k-1],
			ly_s[k-1].q);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k] <= tag_s[k-1];
				num_s[k] <= num_s[k-1];
				den_s[k] <= den_s[k-1];
				mx_s[k]  <= mx_s[k-1] << 1;
				my_s[k]  <= my_s[k-1] << 1;
				lx_s[k]  <= nx;
				ly_s[k]  <= ny;
			end
		end
	end

	// Round to nearest: bump when twice the remainder reaches den
	logic rnd_x;
	logic rnd_y;

	assign rnd_x = (lx_s[NSTEP].r << 1) >= RW'(den_s[NSTEP]);
	assign rnd_y = (ly_s[NSTEP].r << 1) >= RW'(den_s[NSTEP]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_tag <= tag_s[NSTEP];
			q_x     <= lx_s[NSTEP].q + MW'(rnd_x);
			q_y     <= ly_s[NSTEP].q + MW'(rnd_y);
		end
	end

endmodule

FILE: hw/rtl/segment_crossing_point.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// segments  seg_valid / seg_ready   seg : scp_pkg::scp_seg_t
// result    res_valid / res_ready   res : scp_pkg::scp_res_t
//
// Pipeline stages: differences, products, side tests, 17 division steps
// (one per magnitude bit of the segment delta), rounding, output register.
// One request enters every cycle while no result waits at the output.
// Reset clears only the valid bits.
// A result held at the output freezes the whole pipeline; nothing is dropped.
module segment_crossing_point (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              seg_valid,
	output logic              seg_ready,
	input  scp_pkg::scp_seg_t seg,
	output logic              res_valid,
	input  logic              res_ready,
	output scp_pkg::scp_res_t res
);

	localparam int CRW = scp_pkg::COORD_W;
	localparam int DW  = scp_pkg::DIFF_W;
	localparam int PW  = scp_pkg::PROD_W;
	localparam int XW  = scp_pkg::CROSS_W;
	localparam int MW  = scp_pkg::MAG_W;
	localparam int SW  = CRW + 2;

	logic en;

	// Pipeline advances unless a result waits
	assign en        = !res_valid || res_ready;
	assign seg_ready = en;

	// Stage 1: coordinate differences
	logic                  vld_s1;
	logic signed [DW-1:0]  dax_s1, day_s1, dbx_s1, dby_s1;
	logic signed [DW-1:0]  ex_s1, ey_s1, fx_s1, fy_s1, gx_s1, gy_s1;
	logic signed [CRW-1:0] ax_s1, ay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= seg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dax_s1 <= DW'(seg.seg_a_end_x) - DW'(seg.seg_a_start_x);
			day_s1 <= DW'(seg.seg_a_end_y) - DW'(seg.seg_a_start_y);
			dbx_s1 <= DW'(seg.seg_b_end_x) - DW'(seg.seg_b_start_x);
			dby_s1 <= DW'(seg.seg_b_end_y) - DW'(seg.seg_b_start_y);
			ex_s1  <= DW'(seg.seg_b_start_x) - DW'(seg.seg_a_start_x);
			ey_s1  <= DW'(seg.seg_b_start_y) - DW'(seg.seg_a_start_y);
			fx_s1  <= DW'(seg.seg_b_end_x) - DW'(seg.seg_a_start_x);
			fy_s1  <= DW'(seg.seg_b_end_y) - DW'(seg.seg_a_start_y);
			gx_s1  <= DW'(seg.seg_a_end_x) - DW'(seg.seg_b_start_x);
			gy_s1  <= DW'(seg.seg_a_end_y) - DW'(seg.seg_b_start_y);
			ax_s1  <= seg.seg_a_start_x;
			ay_s1  <= seg.seg_a_start_y;
		end
	end

	// Stage 2: the ten products
	logic                  vld_s2;
	logic signed [PW-1:0]  p_dayex_s2, p_daxey_s2, p_dayfx_s2, p_daxfy_s2;
	logic signed [PW-1:0]  p_dbxey_s2, p_dbyex_s2, p_dbygx_s2, p_dbxgy_s2;
	logic signed [PW-1:0]  p_dbxday_s2, p_dbydax_s2;
	logic signed [DW-1:0]  dax_s2, day_s2;
	logic signed [CRW-1:0] ax_s2, ay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_dayex_s2  <= PW'(day_s1) * PW'(ex_s1);
			p_daxey_s2  <= PW'(dax_s1) * PW'(ey_s1);
			p_dayfx_s2  <= PW'(day_s1) * PW'(fx_s1);
			p_daxfy_s2  <= PW'(dax_s1) * PW'(fy_s1);
			p_dbxey_s2  <= PW'(dbx_s1) * PW'(ey_s1);
			p_dbyex_s2  <= PW'(dby_s1) * PW'(ex_s1);
			p_dbygx_s2  <= PW'(dby_s1) * PW'(gx_s1);
			p_dbxgy_s2  <= PW'(dbx_s1) * PW'(gy_s1);
			p_dbxday_s2 <= PW'(dbx_s1) * PW'(day_s1);
			p_dbydax_s2 <= PW'(dby_s1) * PW'(dax_s1);
			dax_s2      <= dax_s1;
			day_s2      <= day_s1;
			ax_s2       <= ax_s1;
			ay_s2       <= ay_s1;
		end
	end

	// Stage 3: side values, det and the oriented hit test
	logic signed [XW-1:0] side_a_bs, side_a_be, side_b_ae, num_c, det_c;
	logic                 hit_c;

	assign side_a_bs = XW'(p_dayex_s2) - XW'(p_daxey_s2);
	assign side_a_be = XW'(p_dayfx_s2) - XW'(p_daxfy_s2);
	assign num_c     = XW'(p_dbxey_s2) - XW'(p_dbyex_s2);  // also side of A start vs B
	assign side_b_ae = XW'(p_dbygx_s2) - XW'(p_dbxgy_s2);
	assign det_c     = XW'(p_dbxday_s2) - XW'(p_dbydax_s2);
	assign hit_c     = side_a_bs[XW-1] && !side_a_be[XW-1] && (side_a_be != '0) &&
		!num_c[XW-1] && (num_c != '0) && side_b_ae[XW-1] && (det_c != '0);

	logic              vld_s3;
	scp_pkg::scp_tag_t tag_s3;
	logic [XW-1:0]     num_s3, den_s3;
	logic [MW-1:0]     magx_s3, magy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	// On a hit the crossing lies inside A, so 0 < num < det
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3.hit    <= hit_c;
			tag_s3.neg_x  <= dax_s2[DW-1];
			tag_s3.neg_y  <= day_s2[DW-1];
			tag_s3.base_x <= ax_s2;
			tag_s3.base_y <= ay_s2;
			num_s3        <= num_c;
			den_s3        <= det_c;
			magx_s3       <= dax_s2[DW-1] ? MW'(-dax_s2) : MW'(dax_s2);
			magy_s3       <= day_s2[DW-1] ? MW'(-day_s2) : MW'(day_s2);
		end
	end

	// Rounded offsets |dA| * num / det
	logic              div_vld;
	scp_pkg::scp_tag_t div_tag;
	logic [MW-1:0]     div_qx, div_qy;

	scp_round_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.in_tag  (tag_s3),
		.num     (num_s3),
		.den     (den_s3),
		.mag_x   (magx_s3),
		.mag_y   (magy_s3),
		.out_vld (div_vld),
		.out_tag (div_tag),
		.q_x     (div_qx),
		.q_y     (div_qy)
	);

	// Apply sign, add the start point, zero on a miss
	logic signed [SW-1:0] off_x, off_y, sum_x, sum_y;

	assign off_x = div_tag.neg_x ? -SW'(div_qx) : SW'(div_qx);
	assign off_y = div_tag.neg_y ? -SW'(div_qy) : SW'(div_qy);
	assign sum_x = SW'(div_tag.base_x) + off_x;
	assign sum_y = SW'(div_tag.base_y) + off_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.hit     <= div_tag.hit;
			res.cross_x <= div_tag.hit ? CRW'(sum_x) : '0;
			res.cross_y <= div_tag.hit ? CRW'(sum_y) : '0;
		end
	end

	// A miss reports the origin
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.cross_x == '0 && res.cross_y == '0)
		else $error("miss with nonzero coordinates");

	// Divider precondition on every hit
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && tag_s3.hit |-> num_s3 < den_s3 && num_s3 != '0)
		else $error("hit with num outside (0, det)");

	// A waiting result is never dropped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("pending result lost");

	// A frozen pipeline takes no request
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !seg_ready)
		else $error("request taken while stalled");

endmodule
